// ===== rtl/core/fbfl_pkg.sv =====
package fbfl_pkg;

  // field widths of the request and result beats
  localparam int INDEX_W  = 6;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;

  // largest block count the index fields can address
  localparam int HW_MAX_COUNT = 64;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_type_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EXHAUSTED = 2'd1,
    STATUS_BAD_FREE  = 2'd2
  } status_t;

endpackage

// ===== rtl/core/fbfl_ram.sv =====
module fbfl_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/fixed_block_free_list_allocator.sv =====
// LIFO free list of block indices; links live in a RAM with a registered read port.
// A request beat is answered on the output in the cycle after it is taken.
// Throughput: one request per cycle while results drain; a held result or a count write stalls it.
// The link of the current head is prefetched so back-to-back allocates pop without a bubble.
// Reset (synchronous, rst_n low) or a count write rebuilds the list at once:
// all blocks below the count free, highest index first; no clearing pass.
module fixed_block_free_list_allocator #(
  parameter int NUM_BLOCKS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_wr_en,
  input  logic [fbfl_pkg::COUNT_W-1:0]   cfg_wr_data,
  // request channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_req_type,
  input  logic [fbfl_pkg::INDEX_W-1:0]   in_release_index,
  input  logic                           in_release_is_null,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [fbfl_pkg::STATUS_W-1:0]  out_status,
  output logic [fbfl_pkg::INDEX_W-1:0]   out_granted_index
);

  localparam int DEPTH = (NUM_BLOCKS < fbfl_pkg::HW_MAX_COUNT) ?
                         NUM_BLOCKS : fbfl_pkg::HW_MAX_COUNT;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = fbfl_pkg::COUNT_W;
  localparam int IW = fbfl_pkg::INDEX_W;

  localparam logic [CW-1:0] RST_COUNT     = CW'(DEPTH);
  localparam logic [AW-1:0] RST_HEAD      = AW'(DEPTH - 1);
  localparam logic [AW-1:0] RST_HEAD_LINK = AW'(DEPTH - 2);

  // control state
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    free_cnt_r, free_cnt_nxt;
  logic [AW-1:0]    head_r, head_nxt;
  logic [AW-1:0]    head_link_r, head_link_nxt;
  logic             from_ram_r, from_ram_nxt;
  logic [DEPTH-1:0] alloc_r, alloc_nxt;
  logic [DEPTH-1:0] link_wr_r, link_wr_nxt;
  logic             out_valid_r, out_valid_nxt;

  // prefetch bookkeeping
  logic [AW-1:0]    rd_addr_r, rd_addr_nxt;
  logic             rd_wr_r, rd_wr_nxt;

  // result payload
  logic [fbfl_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [IW-1:0]                 out_granted_r, out_granted_nxt;

  // link RAM port signals
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [AW-1:0]    ram_wdata;
  logic [AW-1:0]    ram_rdata;

  logic             in_fire;
  logic [AW-1:0]    cur_link;
  logic [AW-1:0]    rd_dflt;
  logic [CW-1:0]    cfg_count;
  logic [AW-1:0]    rel_idx;
  logic             rel_in_range;
  logic             rel_ok;
  logic             nonempty;

  // no request is taken in the cycle of a count write
  assign in_ready = (!out_valid_r || out_ready) && !cfg_wr_en;
  assign in_fire  = in_valid && in_ready;
  assign nonempty = (free_cnt_r != '0);

  // an entry never written since the rebuild links to the index below it
  assign rd_dflt  = (rd_addr_r == '0) ? '0 : rd_addr_r - AW'(1);
  assign cur_link = from_ram_r ? (rd_wr_r ? ram_rdata : rd_dflt) : head_link_r;

  // saturate the written count to the pool size
  assign cfg_count = (cfg_wr_data > CW'(DEPTH)) ? CW'(DEPTH) : cfg_wr_data;

  // free request checks
  assign rel_idx      = in_release_index[AW-1:0];
  assign rel_in_range = (CW'(in_release_index) < count_r);
  assign rel_ok       = !in_release_is_null && rel_in_range &&
                        (rel_in_range ? alloc_r[rel_idx] : 1'b0);

  // link write on a good free
  assign ram_we    = in_fire && !cfg_wr_en &&
                     (in_req_type == fbfl_pkg::REQ_FREE) && rel_ok;
  assign ram_waddr = rel_idx;
  assign ram_wdata = nonempty ? head_r : '0;

  fbfl_ram #(
    .WIDTH (AW),
    .DEPTH (DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cur_link),
    .rdata (ram_rdata)
  );

  // next-state logic: rebuild, pop or push
  always_comb begin
    count_nxt       = count_r;
    free_cnt_nxt    = free_cnt_r;
    head_nxt        = head_r;
    head_link_nxt   = cur_link;
    from_ram_nxt    = 1'b0;
    alloc_nxt       = alloc_r;
    link_wr_nxt     = link_wr_r;
    rd_addr_nxt     = rd_addr_r;
    rd_wr_nxt       = rd_wr_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_status_nxt  = out_status_r;
    out_granted_nxt = out_granted_r;

    if (cfg_wr_en) begin
      count_nxt     = cfg_count;
      free_cnt_nxt  = cfg_count;
      head_nxt      = (cfg_count != '0) ? AW'(cfg_count - CW'(1)) : '0;
      head_link_nxt = (cfg_count > CW'(1)) ? AW'(cfg_count - CW'(2)) : '0;
      alloc_nxt     = '0;
      link_wr_nxt   = '0;
    end else if (in_fire) begin
      out_valid_nxt   = 1'b1;
      out_granted_nxt = '0;
      if (in_req_type == fbfl_pkg::REQ_ALLOC) begin
        if (!nonempty) begin
          out_status_nxt = fbfl_pkg::STATUS_EXHAUSTED;
        end else begin
          // pop: the prefetched link becomes the head, fetch its own link
          out_status_nxt   = fbfl_pkg::STATUS_OK;
          out_granted_nxt  = IW'(head_r);
          alloc_nxt[head_r] = 1'b1;
          free_cnt_nxt     = free_cnt_r - CW'(1);
          head_nxt         = cur_link;
          from_ram_nxt     = 1'b1;
          rd_addr_nxt      = cur_link;
          rd_wr_nxt        = link_wr_r[cur_link];
        end
      end else begin
        if (!rel_ok) begin
          out_status_nxt = fbfl_pkg::STATUS_BAD_FREE;
        end else begin
          // push: the freed block links to the old head
          out_status_nxt     = fbfl_pkg::STATUS_OK;
          alloc_nxt[rel_idx] = 1'b0;
          link_wr_nxt[rel_idx] = 1'b1;
          free_cnt_nxt       = free_cnt_r + CW'(1);
          head_nxt           = rel_idx;
          head_link_nxt      = ram_wdata;
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= RST_COUNT;
      free_cnt_r  <= RST_COUNT;
      head_r      <= RST_HEAD;
      head_link_r <= RST_HEAD_LINK;
      from_ram_r  <= 1'b0;
      alloc_r     <= '0;
      link_wr_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      free_cnt_r  <= free_cnt_nxt;
      head_r      <= head_nxt;
      head_link_r <= head_link_nxt;
      from_ram_r  <= from_ram_nxt;
      alloc_r     <= alloc_nxt;
      link_wr_r   <= link_wr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_addr_r     <= rd_addr_nxt;
    rd_wr_r       <= rd_wr_nxt;
    out_status_r  <= out_status_nxt;
    out_granted_r <= out_granted_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_index = out_granted_r;

  // free blocks and allocated blocks always add up to the count
  a_conserve: assert property (@(posedge clk) disable iff (!rst_n)
    ($countones(alloc_r) + int'(free_cnt_r)) == int'(count_r))
    else $error("allocated plus free blocks differ from the block count");

  // the head of a nonempty list is never an allocated block
  a_head_free: assert property (@(posedge clk) disable iff (!rst_n)
    (free_cnt_r != '0) |-> !alloc_r[head_r])
    else $error("free list head is marked allocated");

  // every taken request beat yields a result beat on the next cycle
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !cfg_wr_en) |=> out_valid_r)
    else $error("request beat produced no result");

  // a refused request never grants an index
  a_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != fbfl_pkg::STATUS_OK)) |-> (out_granted_r == '0))
    else $error("nonzero index on a refused request");

endmodule

// ===== sim/tb_fixed_block_free_list_allocator.sv =====
`timescale 1ns / 1ps

module tb_fixed_block_free_list_allocator;

  localparam int NUM_BLOCKS   = 64;
  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int NUM_PHASES   = 9;
  localparam int INDEX_W      = fbfl_pkg::INDEX_W;
  localparam int COUNT_W      = fbfl_pkg::COUNT_W;
  localparam int STATUS_W     = fbfl_pkg::STATUS_W;
  localparam int HW_MAX_COUNT = fbfl_pkg::HW_MAX_COUNT;

  // pool model plus queue of expected result beats
  typedef struct {
    fbfl_pkg::status_t  status;
    logic [INDEX_W-1:0] granted;
  } grant_result_t;

  class free_list_scoreboard;
    logic [INDEX_W-1:0] next_link[NUM_BLOCKS];
    bit                 allocated[NUM_BLOCKS];
    logic [INDEX_W-1:0] head;
    bit                 nonempty;
    int                 free_total;
    int                 pool_size;
    grant_result_t      grant_queue[$];
    int                 errors;

    function new();
      errors = 0;
      load_pool_size(HW_MAX_COUNT);
    endfunction

    // count write: saturate, then every block below it free, highest first
    function void load_pool_size(int value);
      pool_size = (value > HW_MAX_COUNT) ? HW_MAX_COUNT : value;
      if (pool_size > NUM_BLOCKS) pool_size = NUM_BLOCKS;
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        next_link[i] = (i == 0) ? '0 : INDEX_W'(i - 1);
        allocated[i] = 1'b0;
      end
      free_total = pool_size;
      nonempty   = (pool_size != 0);
      head       = nonempty ? INDEX_W'(pool_size - 1) : '0;
    endfunction

    // apply one accepted request beat and queue its result
    function void note_request(fbfl_pkg::req_type_t req, logic [INDEX_W-1:0] idx,
                               logic is_null);
      grant_result_t r;
      r.status  = fbfl_pkg::STATUS_OK;
      r.granted = '0;
      if (req == fbfl_pkg::REQ_ALLOC) begin
        if (!nonempty) begin
          r.status = fbfl_pkg::STATUS_EXHAUSTED;
        end else begin
          r.granted          = head;
          allocated[head]    = 1'b1;
          head               = next_link[r.granted];
          free_total         = (free_total > 0) ? free_total - 1 : 0;
          nonempty           = (free_total != 0);
        end
      end else if (is_null || int'(idx) >= pool_size || !allocated[idx]) begin
        r.status = fbfl_pkg::STATUS_BAD_FREE;
      end else begin
        next_link[idx] = nonempty ? head : '0;
        head           = idx;
        allocated[idx] = 1'b0;
        free_total     = free_total + 1;
        nonempty       = 1'b1;
      end
      grant_queue.push_back(r);
    endfunction

    // a block currently handed out, or -1 when none is
    function int random_allocated();
      int found[$];
      for (int i = 0; i < NUM_BLOCKS; i++)
        if (allocated[i]) found.push_back(i);
      if (found.size() == 0) return -1;
      return found[$urandom_range(found.size() - 1)];
    endfunction

    function int pending();
      return grant_queue.size();
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // compare one accepted result beat with the oldest expectation
    task check_result(logic [STATUS_W-1:0] status, logic [INDEX_W-1:0] granted);
      grant_result_t r;
      if (grant_queue.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing expected (status %0d index %0d)",
                                  status, granted));
      end else begin
        r = grant_queue.pop_front();
        if (status !== r.status)
          report_mismatch($sformatf("status %0d, expected %0d", status, r.status));
        if (granted !== r.granted)
          report_mismatch($sformatf("granted_index %0d, expected %0d", granted, r.granted));
      end
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [COUNT_W-1:0]  cfg_wr_data;
  logic                in_valid;
  logic                in_ready;
  logic                in_req_type;
  logic [INDEX_W-1:0]  in_release_index;
  logic                in_release_is_null;
  logic                out_valid;
  logic                out_ready;
  logic [STATUS_W-1:0] out_status;
  logic [INDEX_W-1:0]  out_granted_index;

  free_list_scoreboard sb = new();
  bit idle_on      = 1'b1;
  bit hold_request = 1'b0;
  int quiet_cycles = 0;

  always #4 clk = ~clk;

  fixed_block_free_list_allocator #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_release_index  (in_release_index),
    .in_release_is_null(in_release_is_null),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_granted_index (out_granted_index)
  );

  // result side: check beats, random back-pressure, long hold on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        sb.check_result(out_status, out_granted_index);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(idle_on && $urandom_range(99) < 28);
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // offer one request beat, with random idle cycles ahead of it
  task automatic send_request(fbfl_pkg::req_type_t req, logic [INDEX_W-1:0] idx,
                              logic is_null);
    while (idle_on && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_req_type        <= req;
    in_release_index   <= idx;
    in_release_is_null <= is_null;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(req, idx, is_null);
  endtask

  task automatic alloc_block();
    send_request(fbfl_pkg::REQ_ALLOC, INDEX_W'($urandom), 1'($urandom));
  endtask

  // mostly well-formed traffic: allocs and frees of live blocks, some noise
  task automatic send_random_request(int alloc_bias);
    int                  pick;
    fbfl_pkg::req_type_t req;
    logic [INDEX_W-1:0]  idx;
    logic                is_null;
    idx     = INDEX_W'($urandom);
    is_null = 1'($urandom);
    req     = fbfl_pkg::req_type_t'(1'($urandom));
    if ($urandom_range(99) >= 12) begin
      pick = sb.random_allocated();
      if (pick < 0 || $urandom_range(99) < alloc_bias) begin
        req = fbfl_pkg::REQ_ALLOC;
      end else begin
        req     = fbfl_pkg::REQ_FREE;
        idx     = INDEX_W'(pick);
        is_null = 1'b0;
      end
    end
    send_request(req, idx, is_null);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // count write only with the pool idle
  task automatic write_pool_size(int value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= COUNT_W'(value);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.load_pool_size(value);
  endtask

  initial begin
    int phase_counts[NUM_PHASES];
    int phase_items[NUM_PHASES];
    int alloc_bias;

    phase_counts       = '{64, 1, 2, 0, 100, 33, 64, 5, 127};
    phase_items        = '{300, 200, 260, 60, 300, 260, 300, 200, 200};
    rst_n              = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    in_valid           = 1'b0;
    in_req_type        = 1'b0;
    in_release_index   = '0;
    in_release_is_null = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // full pool after reset: pop, push back, double and null and stray frees
    alloc_block();
    send_request(fbfl_pkg::REQ_FREE, 6'd63, 1'b0);
    send_request(fbfl_pkg::REQ_FREE, 6'd63, 1'b0);
    send_request(fbfl_pkg::REQ_FREE, 6'd0, 1'b1);
    send_request(fbfl_pkg::REQ_FREE, 6'd63, 1'b1);
    send_request(fbfl_pkg::REQ_FREE, 6'd0, 1'b0);

    // three blocks: exhaust, out of range frees, refill
    write_pool_size(3);
    repeat (4) alloc_block();
    send_request(fbfl_pkg::REQ_FREE, 6'd63, 1'b0);
    send_request(fbfl_pkg::REQ_FREE, 6'd3, 1'b0);
    send_request(fbfl_pkg::REQ_FREE, 6'd0, 1'b0);
    send_request(fbfl_pkg::REQ_FREE, 6'd0, 1'b0);
    send_request(fbfl_pkg::REQ_FREE, 6'd2, 1'b1);
    alloc_block();
    send_request(fbfl_pkg::REQ_FREE, 6'd1, 1'b0);
    send_request(fbfl_pkg::REQ_FREE, 6'd2, 1'b0);
    alloc_block();

    // empty pool
    write_pool_size(0);
    alloc_block();
    send_request(fbfl_pkg::REQ_FREE, 6'd0, 1'b0);

    // oversized count saturates to a full pool
    write_pool_size(127);
    alloc_block();
    send_request(fbfl_pkg::REQ_FREE, 6'd63, 1'b0);
    send_request(fbfl_pkg::REQ_ALLOC, 6'd63, 1'b1);

    // single block
    write_pool_size(1);
    alloc_block();
    alloc_block();

    // random phases over several counts
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_pool_size(phase_counts[p]);
      idle_on    = (p != 6);
      alloc_bias = 50;
      for (int n = 0; n < phase_items[p]; n++) begin
        if (n % 40 == 0) alloc_bias = $urandom_range(15, 95);
        if (p == 0 && n == 150) wait_drained();
        if (p == 2 && n == 80) hold_request = 1'b1;
        send_random_request(alloc_bias);
      end
    end
    idle_on = 1'b1;

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d expected results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/fbfl_pkg.sv
rtl/core/fbfl_ram.sv
rtl/core/fixed_block_free_list_allocator.sv
sim/tb_fixed_block_free_list_allocator.sv
